### sv/ffrx_pkg.sv
package ffrx_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned ValueW     = 16;
  localparam int unsigned FrameLen   = 10;
  localparam int unsigned PayloadLen = 7;
  localparam int unsigned CountW     = 4;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned OutDataW   = 56;

  localparam logic [ByteW-1:0] SyncFirstRst  = 8'd64;
  localparam logic [ByteW-1:0] SyncSecondRst = 8'd94;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SYNC_FIRST  = 1'b0,
    CFG_SYNC_SECOND = 1'b1
  } cfg_idx_e;

  localparam logic [CountW-1:0] CntHunt     = 4'd0;
  localparam logic [CountW-1:0] CntSecond   = 4'd1;
  localparam logic [CountW-1:0] CntPayload  = 4'd2;
  localparam logic [CountW-1:0] CntChecksum = CountW'(FrameLen - 1);

  typedef struct packed {
    logic [ValueW-1:0] value_c;
    logic [ValueW-1:0] value_b;
    logic [ValueW-1:0] value_a;
    logic [ByteW-1:0]  command;
  } result_t;

  typedef struct packed {
    logic              in_frame;
    logic [CountW-1:0] byte_count;
  } dfr_status_t;

endpackage

### sv/ffrx_deframer.sv
module ffrx_deframer (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic [ffrx_pkg::ByteW-1:0] rx_byte_i,
  input  logic [ffrx_pkg::ByteW-1:0] sync_first_i,
  input  logic [ffrx_pkg::ByteW-1:0] sync_second_i,
  output logic                    res_valid_o,
  output ffrx_pkg::result_t       res_o,
  output ffrx_pkg::dfr_status_t   status_o
);
  import ffrx_pkg::*;

  logic [CountW-1:0] count_q, count_d;
  logic [ByteW-1:0]  sum_q, sum_d;
  logic [ByteW-1:0]  payload_q [PayloadLen];

  always_comb begin
    count_d     = count_q;
    sum_d       = sum_q;
    res_valid_o = 1'b0;
    if (accept_i) begin
      if (count_q == CntHunt) begin
        if (rx_byte_i == sync_first_i) begin
          count_d = CntSecond;
          sum_d   = rx_byte_i;
        end
      end else if (count_q == CntSecond) begin
        if (rx_byte_i == sync_second_i) begin
          count_d = CntPayload;
          sum_d   = sum_q + rx_byte_i;
        end else begin
          count_d = CntHunt;
          sum_d   = '0;
        end
      end else if (count_q < CntChecksum) begin
        count_d = count_q + 1'b1;
        sum_d   = sum_q + rx_byte_i;
      end else begin
        count_d     = CntHunt;
        sum_d       = '0;
        res_valid_o = (rx_byte_i == sum_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CntHunt;
      sum_q   <= '0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
    end
  end

  for (genvar i = 0; i < PayloadLen; i++) begin : g_payload
    always_ff @(posedge clk_i) begin
      if (accept_i && count_q == CountW'(i + 2)) begin
        payload_q[i] <= rx_byte_i;
      end
    end
  end

  assign res_o.command = payload_q[0];
  assign res_o.value_a = {payload_q[1], payload_q[2]};
  assign res_o.value_b = {payload_q[3], payload_q[4]};
  assign res_o.value_c = {payload_q[5], payload_q[6]};

  assign status_o.in_frame   = (count_q != CntHunt);
  assign status_o.byte_count = count_q;

endmodule

### sv/ffrx_out_buf.sv
module ffrx_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  ffrx_pkg::result_t res_i,
  output logic              room_o,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output ffrx_pkg::result_t m_res_o
);
  import ffrx_pkg::*;

  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;
  logic    advance;

  assign advance = !out_valid_q || m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q  <= skid_valid_q || res_valid_i;
      skid_valid_q <= 1'b0;
    end else if (res_valid_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= skid_valid_q ? skid_q : res_i;
    end else if (res_valid_i) begin
      skid_q <= res_i;
    end
  end

  assign room_o     = !skid_valid_q;
  assign m_tvalid_o = out_valid_q;
  assign m_res_o    = out_q;

endmodule

### sv/fixed_frame_receiver_sum_check.sv
// Channel | Direction | Payload
// s_axis  | in        | tdata[7:0] rx_byte
// m_axis  | out       | tdata[7:0] command, [23:8] value_a, [39:24] value_b, [55:40] value_c
// cfg     | in        | index 0 sync_first, index 1 sync_second
//
// One word is accepted per cycle while s_axis_tready is high, advancing the frame state.
// A result is registered into the output register, or the skid entry while it is stalled.
// A two-entry output buffer holds results, so s_axis_tready only drops while both are full.
// Reset restores the sync bytes to '@' and '^' and returns to hunting for a start word.
module fixed_frame_receiver_sum_check (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [ffrx_pkg::ByteW-1:0]     s_axis_tdata,   // [7:0] rx_byte
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [ffrx_pkg::OutDataW-1:0]  m_axis_tdata,   // command, value_a, value_b, value_c
  input  logic                           cfg_we_i,
  input  logic [ffrx_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ffrx_pkg::ByteW-1:0]     cfg_wdata_i
);
  import ffrx_pkg::*;

  logic [ByteW-1:0] sync_first_q, sync_second_q;
  logic             accept, res_valid;
  result_t          res, m_res;
  dfr_status_t      status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= SyncFirstRst;
      sync_second_q <= SyncSecondRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SYNC_FIRST:  sync_first_q  <= cfg_wdata_i;
        CFG_SYNC_SECOND: sync_second_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  ffrx_deframer u_deframer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .rx_byte_i     (s_axis_tdata),
    .sync_first_i  (sync_first_q),
    .sync_second_i (sync_second_q),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .status_o      (status)
  );

  ffrx_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .room_o      (s_axis_tready),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_res_o     (m_res)
  );

  assign m_axis_tdata = m_res;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.byte_count <= CntChecksum)
    else $error("frame byte count out of range");

  a_result_at_checksum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> accept && status.in_frame && status.byte_count == CntChecksum)
    else $error("result raised outside the checksum word");

  a_result_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |=> m_axis_tvalid)
    else $error("result lost before the output register");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with an empty output register");

endmodule

### test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ffrx_pkg::*;

  class frame_scoreboard;
    logic [ByteW-1:0]  sync_first;
    logic [ByteW-1:0]  sync_second;
    bit                in_frame;
    logic [CountW-1:0] byte_count;
    logic [ByteW-1:0]  running_sum;
    logic [ByteW-1:0]  payload [PayloadLen];
    result_t           frames_due [$];
    int unsigned       errors;

    function new();
      sync_first  = SyncFirstRst;
      sync_second = SyncSecondRst;
      errors      = 0;
      hunt();
    endfunction

    function void hunt();
      in_frame    = 1'b0;
      byte_count  = CntHunt;
      running_sum = '0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [ByteW-1:0] val);
      case (idx)
        CFG_SYNC_FIRST:  sync_first  = val;
        CFG_SYNC_SECOND: sync_second = val;
        default: ;
      endcase
    endfunction

    function void note_byte(logic [ByteW-1:0] b);
      result_t r;
      if (!in_frame) begin
        if (b == sync_first) begin
          in_frame    = 1'b1;
          byte_count  = CntSecond;
          running_sum = b;
        end
      end else if (byte_count == CntSecond) begin
        if (b != sync_second) begin
          hunt();
        end else begin
          running_sum = running_sum + b;
          byte_count  = CntPayload;
        end
      end else if (byte_count < CntChecksum) begin
        payload[byte_count - CntPayload] = b;
        running_sum = running_sum + b;
        byte_count  = byte_count + 1'b1;
      end else begin
        if (b == running_sum) begin
          r.command = payload[0];
          r.value_a = {payload[1], payload[2]};
          r.value_b = {payload[3], payload[4]};
          r.value_c = {payload[5], payload[6]};
          frames_due.push_back(r);
        end
        hunt();
      end
    endfunction

    function void check_result(logic [OutDataW-1:0] raw);
      result_t got;
      result_t exp;
      got = result_t'(raw);
      if (frames_due.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, raw);
        errors++;
        return;
      end
      exp = frames_due.pop_front();
      if (got.command != exp.command) begin
        $display("%0t: command expected %h actual %h", $time, exp.command, got.command);
        errors++;
      end
      if (got.value_a != exp.value_a) begin
        $display("%0t: value_a expected %h actual %h", $time, exp.value_a, got.value_a);
        errors++;
      end
      if (got.value_b != exp.value_b) begin
        $display("%0t: value_b expected %h actual %h", $time, exp.value_b, got.value_b);
        errors++;
      end
      if (got.value_c != exp.value_c) begin
        $display("%0t: value_c expected %h actual %h", $time, exp.value_c, got.value_c);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return frames_due.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [ByteW-1:0]    s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [ByteW-1:0]    cfg_wdata_i = '0;
  bit                  calm = 1'b0;

  frame_scoreboard sb = new();

  fixed_frame_receiver_sum_check dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 26);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata);
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 26) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_byte(b);
  endtask

  // Sends the sync pair, the payload and the checksum offset by cks_err,
  // cut short after n words.
  task automatic send_frame(input logic [ByteW-1:0] pl [PayloadLen],
                            input logic [ByteW-1:0] cks_err, input int unsigned n);
    logic [ByteW-1:0] word_seq [FrameLen];
    logic [ByteW-1:0] cks;
    word_seq[0] = sb.sync_first;
    word_seq[1] = sb.sync_second;
    cks = word_seq[0] + word_seq[1];
    for (int i = 0; i < PayloadLen; i++) begin
      word_seq[i + 2] = pl[i];
      cks = cks + pl[i];
    end
    word_seq[FrameLen - 1] = cks + cks_err;
    for (int i = 0; i < n; i++) send_byte(word_seq[i]);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [ByteW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_phase(input int unsigned target);
    int unsigned      sent;
    int unsigned      kind;
    logic [ByteW-1:0] pl [PayloadLen];
    logic [ByteW-1:0] bad;
    sent = 0;
    while (sent < target) begin
      kind = $urandom_range(99);
      foreach (pl[i]) pl[i] = 8'($urandom_range(255));
      if (kind < 70) begin
        send_frame(pl, 8'd0, FrameLen);
        sent += FrameLen;
      end else if (kind < 80) begin
        send_frame(pl, 8'($urandom_range(255, 1)), FrameLen);
        sent += FrameLen;
      end else if (kind < 88) begin
        if ($urandom_range(1) == 1 && sb.sync_first != sb.sync_second) begin
          bad = sb.sync_first;
        end else begin
          do bad = 8'($urandom_range(255)); while (bad == sb.sync_second);
        end
        send_byte(sb.sync_first);
        send_byte(bad);
        sent += 2;
      end else if (kind < 94) begin
        kind = $urandom_range(FrameLen - 1, 2);
        send_frame(pl, 8'd0, kind);
        sent += kind;
      end else begin
        repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    logic [ByteW-1:0] pl [PayloadLen];
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SyncFirstRst);
    send_byte(SyncFirstRst);
    send_byte(SyncSecondRst);
    foreach (pl[i]) pl[i] = 8'hFF;
    send_frame(pl, 8'd0, FrameLen);
    foreach (pl[i]) pl[i] = 8'h00;
    send_frame(pl, 8'd1, FrameLen);
    drain();

    write_reg(CFG_SYNC_FIRST, 8'h00);
    write_reg(CFG_SYNC_SECOND, 8'hFF);
    run_phase(255);
    drain();

    write_reg(CFG_SYNC_FIRST, 8'hFF);
    write_reg(CFG_SYNC_SECOND, 8'h00);
    calm = 1'b1;
    run_phase(255);
    drain();
    calm = 1'b0;

    write_reg(CFG_SYNC_FIRST, 8'h55);
    write_reg(CFG_SYNC_SECOND, 8'h55);
    run_phase(255);
    drain();

    write_reg(CFG_SYNC_FIRST, 8'($urandom_range(255)));
    write_reg(CFG_SYNC_SECOND, 8'($urandom_range(255)));
    run_phase(255);
    drain();

    write_reg(CFG_SYNC_FIRST, SyncFirstRst);
    write_reg(CFG_SYNC_SECOND, SyncSecondRst);
    run_phase(255);
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
